// File: sv/abkf_pkg.sv
// ----------------------------------------------------------------------------
// abkf_pkg
// Shared types and constants of the angle and gyro-bias Kalman filter.
// ----------------------------------------------------------------------------
`default_nettype none
package abkf_pkg;
    localparam int          ValueWidthDefault = 32;
    localparam int          NoiseWidth        = 31;
    localparam int          FieldWidth        = 32;
    localparam int          DtWidth           = 16;
    localparam int          FracQ28           = 28;
    localparam int          FracDt            = 16;
    localparam logic [30:0] AngleNoiseReset   = 31'd268435;
    localparam logic [30:0] BiasNoiseReset    = 31'd805306;
    localparam logic [30:0] MeasNoiseReset    = 31'd8053063;

    typedef enum logic [1:0] {
        t_REG_ANGLE_NOISE = 2'd0,
        t_REG_BIAS_NOISE  = 2'd1,
        t_REG_MEAS_NOISE  = 2'd2
    } t_reg_idx;

    localparam logic CmdUpdate = 1'b0;
    localparam logic CmdLoad   = 1'b1;
endpackage
`default_nettype wire

// File: sv/angle_bias_kalman_filter.sv
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter
// Two-state angle / gyro-bias Kalman filter in fixed point.
// ----------------------------------------------------------------------------
// Input words (cmd, measured_angle, gyro_rate, time_step) arrive on a
// valid/stall channel; each gives one result word (filtered_angle,
// unbiased_rate) on the output valid/stall channel.
// An update word runs a sequencer over one shared 32x32 multiplier and one
// saturating adder, plus a one-bit-a-cycle restoring divider for the two
// gains. One word is in work at a time: the input stalls from acceptance
// until the result is taken. While the receiver stalls the result holds
// and no new word is taken.
// Reset (synchronous, active low) clears the state and covariance and
// restores the noise registers to 0.001, 0.003 and 0.03 in Q4.28.
// Noise registers must be written through i_cfg_we/i_cfg_idx/i_cfg_data
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none
module angle_bias_kalman_filter
    import abkf_pkg::*;
#(
    parameter int VALUE_WIDTH = ValueWidthDefault
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_idx,
    input  wire logic [NoiseWidth-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output      logic                  o_stall,
    input  wire logic                  i_cmd,
    input  wire logic signed [FieldWidth-1:0] i_measured_angle,
    input  wire logic signed [FieldWidth-1:0] i_gyro_rate,
    input  wire logic [DtWidth-1:0]    i_time_step,
    output      logic                  o_valid,
    input  wire logic                  i_stall,
    output      logic signed [FieldWidth-1:0] o_filtered_angle,
    output      logic signed [FieldWidth-1:0] o_unbiased_rate
);
    localparam int VW = (VALUE_WIDTH > 32) ? 32 : ((VALUE_WIDTH < 16) ? 16 : VALUE_WIDTH);
    localparam logic signed [63:0] SatHi = (64'sd1 <<< (VW - 1)) - 64'sd1;
    localparam logic signed [63:0] SatLo = -SatHi - 64'sd1;

    typedef enum logic [4:0] {
        S_IDLE, S_RATE, S_ANG_M, S_ANG_A, S_P11_M, S_T, S_P00_M, S_P00_A,
        S_P01, S_P10, S_P11N_M, S_P11N_A, S_S, S_DIV0, S_DIV1, S_Y,
        S_ANGC_M, S_ANGC_A, S_BIAS_M, S_BIAS_A, S_C00_M, S_C01_M, S_C10_M,
        S_C11_M, S_C_A, S_OUT
    } t_state;

    t_state r_state;
    logic [NoiseWidth-1:0] r_an, r_bn, r_mn;
    logic signed [31:0] r_ang, r_bias, r_rate, r_p00, r_p01, r_p10, r_p11;
    logic signed [31:0] r_meas, r_gyro, r_dtp11, r_t, r_k0, r_k1, r_y;
    logic signed [31:0] r_q00, r_q01;
    logic [DtWidth-1:0] r_dt;
    logic signed [63:0] r_prod;
    logic signed [33:0] r_s;
    logic [1:0] r_ci;
    // divider
    logic [63:0] r_rem;
    logic [63:0] r_quo;
    logic [5:0]  r_dcnt;
    logic        r_dneg;
    logic        r_dbusy;
    logic signed [31:0] r_oa, r_or;

    // shared multiplier
    logic signed [31:0] m_a, m_b;
    logic signed [63:0] m_p;
    logic [5:0] m_sh;
    always_comb begin
        m_a  = 32'sd0;
        m_b  = 32'sd0;
        m_sh = 6'(FracQ28);
        unique case (r_state)
            S_ANG_M:  begin m_a = r_rate; m_b = {16'd0, r_dt}; m_sh = 6'(FracDt); end
            S_P11_M:  begin m_a = r_p11;  m_b = {16'd0, r_dt}; m_sh = 6'(FracDt); end
            S_P00_M:  begin m_a = r_t;    m_b = {16'd0, r_dt}; m_sh = 6'(FracDt); end
            S_P11N_M: begin m_a = {1'b0, r_bn}; m_b = {16'd0, r_dt}; m_sh = 6'(FracDt); end
            S_ANGC_M: begin m_a = r_k0; m_b = r_y; end
            S_BIAS_M: begin m_a = r_k1; m_b = r_y; end
            S_C00_M:  begin m_a = r_k0; m_b = r_q00; end
            S_C01_M:  begin m_a = r_k0; m_b = r_q01; end
            S_C10_M:  begin m_a = r_k1; m_b = r_q00; end
            S_C11_M:  begin m_a = r_k1; m_b = r_q01; end
            default:  ;
        endcase
        m_p = (64'(m_a) * 64'(m_b) + (64'sd1 <<< (m_sh - 6'd1))) >>> m_sh;
    end

    // shared saturating adder
    logic signed [63:0] a_x, a_y, a_sum, a_sat;
    always_comb begin
        a_x = 64'sd0;
        a_y = 64'sd0;
        unique case (r_state)
            S_RATE:   begin a_x = 64'(r_gyro); a_y = -64'(r_bias); end
            S_ANG_A:  begin a_x = 64'(r_ang);  a_y = r_prod; end
            S_T:      begin a_x = 64'(r_dtp11) - 64'(r_p01) - 64'(r_p10);
                            a_y = 64'({1'b0, r_an}); end
            S_P00_A:  begin a_x = 64'(r_p00);  a_y = r_prod; end
            S_P01:    begin a_x = 64'(r_p01);  a_y = -64'(r_dtp11); end
            S_P10:    begin a_x = 64'(r_p10);  a_y = -64'(r_dtp11); end
            S_P11N_A: begin a_x = 64'(r_p11);  a_y = r_prod; end
            S_Y:      begin a_x = 64'(r_meas); a_y = -64'(r_ang); end
            S_ANGC_A: begin a_x = 64'(r_ang);  a_y = r_prod; end
            S_BIAS_A: begin a_x = 64'(r_bias); a_y = r_prod; end
            S_C_A: begin
                unique case (r_ci)
                    2'd0: a_x = 64'(r_p00);
                    2'd1: a_x = 64'(r_p01);
                    2'd2: a_x = 64'(r_p10);
                    default: a_x = 64'(r_p11);
                endcase
                a_y = -r_prod;
            end
            default: ;
        endcase
        a_sum = a_x + a_y;
        if (a_sum > SatHi)      a_sat = SatHi;
        else if (a_sum < SatLo) a_sat = SatLo;
        else                    a_sat = a_sum;
    end
    logic signed [31:0] a_w;
    assign a_w = a_sat[31:0];

    // restoring divider step, |num|<<28 / S
    logic [63:0] d_trial;
    logic [63:0] d_rem1;
    logic signed [63:0] d_q;
    logic signed [63:0] d_qsat;
    always_comb begin
        d_rem1  = {r_rem[62:0], r_quo[63]};
        d_trial = d_rem1 - 64'(r_s);
        d_q     = r_dneg ? -$signed(r_quo) : $signed(r_quo);
        if (d_q > SatHi)      d_qsat = SatHi;
        else if (d_q < SatLo) d_qsat = SatLo;
        else                  d_qsat = d_q;
    end

    logic signed [31:0] w_num;
    assign w_num = (r_state == S_S) ? r_p00 : r_p10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_an <= AngleNoiseReset; r_bn <= BiasNoiseReset; r_mn <= MeasNoiseReset;
            r_ang <= '0; r_bias <= '0; r_rate <= '0;
            r_p00 <= '0; r_p01 <= '0; r_p10 <= '0; r_p11 <= '0;
            r_dbusy <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    t_REG_ANGLE_NOISE: r_an <= i_cfg_data;
                    t_REG_BIAS_NOISE:  r_bn <= i_cfg_data;
                    t_REG_MEAS_NOISE:  r_mn <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_meas <= i_measured_angle;
                    r_gyro <= i_gyro_rate;
                    r_dt   <= i_time_step;
                    if (i_cmd == CmdLoad) begin
                        r_ang   <= 32'(i_measured_angle < 32'(SatLo) ? SatLo[31:0] :
                                   (i_measured_angle > 32'(SatHi) ? SatHi[31:0]
                                    : i_measured_angle));
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_RATE;
                    end
                end
                S_RATE:  begin r_rate <= a_w; r_state <= S_ANG_M; end
                S_ANG_M: begin r_prod <= m_p; r_state <= S_ANG_A; end
                S_ANG_A: begin r_ang <= a_w; r_state <= S_P11_M; end
                S_P11_M: begin r_dtp11 <= m_p[31:0]; r_state <= S_T; end
                S_T:     begin r_t <= a_w; r_state <= S_P00_M; end
                S_P00_M: begin r_prod <= m_p; r_state <= S_P00_A; end
                S_P00_A: begin r_p00 <= a_w; r_state <= S_P01; end
                S_P01:   begin r_p01 <= a_w; r_state <= S_P10; end
                S_P10:   begin r_p10 <= a_w; r_state <= S_P11N_M; end
                S_P11N_M: begin r_prod <= m_p; r_state <= S_P11N_A; end
                S_P11N_A: begin
                    r_p11 <= a_w;
                    r_s   <= 34'(r_p00) + 34'({1'b0, r_mn});
                    r_state <= S_S;
                end
                S_S, S_DIV0: begin
                    if (!r_dbusy) begin
                        r_rem  <= '0;
                        r_quo  <= (w_num[31] ? 64'(-64'(w_num)) : 64'(w_num)) << FracQ28;
                        r_dneg <= w_num[31];
                        r_dcnt <= '0;
                        r_dbusy <= 1'b1;
                    end else begin
                        if (d_trial[63] == 1'b0) begin
                            r_rem <= d_trial;
                            r_quo <= {r_quo[62:0], 1'b1};
                        end else begin
                            r_rem <= d_rem1;
                            r_quo <= {r_quo[62:0], 1'b0};
                        end
                        r_dcnt <= r_dcnt + 6'd1;
                        if (r_dcnt == 6'd63) begin
                            r_dbusy <= 1'b0;
                            r_state <= (r_state == S_S) ? S_DIV0 : S_DIV1;
                        end
                    end
                end
                S_DIV1: begin
                    // both quotients done; second is in r_quo
                    r_k1 <= (r_s[33] || r_s == 34'sd0) ? 32'sd0 : d_qsat[31:0];
                    r_state <= S_Y;
                end
                S_Y: begin r_y <= a_w; r_q00 <= r_p00; r_q01 <= r_p01; r_state <= S_ANGC_M; end
                S_ANGC_M: begin r_prod <= m_p; r_state <= S_ANGC_A; end
                S_ANGC_A: begin r_ang <= a_w; r_state <= S_BIAS_M; end
                S_BIAS_M: begin r_prod <= m_p; r_state <= S_BIAS_A; end
                S_BIAS_A: begin r_bias <= a_w; r_ci <= 2'd0; r_state <= S_C00_M; end
                S_C00_M, S_C01_M, S_C10_M, S_C11_M: begin
                    r_prod <= m_p; r_state <= S_C_A;
                end
                S_C_A: begin
                    r_ci <= r_ci + 2'd1;
                    unique case (r_ci)
                        2'd0: begin r_p00 <= a_w; r_state <= S_C01_M; end
                        2'd1: begin r_p01 <= a_w; r_state <= S_C10_M; end
                        2'd2: begin r_p10 <= a_w; r_state <= S_C11_M; end
                        default: begin r_p11 <= a_w; r_state <= S_OUT; end
                    endcase
                end
                S_OUT: begin
                    if (!o_valid) begin
                        o_valid <= 1'b1;
                        r_oa <= r_ang;
                        r_or <= r_rate;
                    end else if (!i_stall) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // first gain cleared when first division ends, captured in S_DIV0 before the second starts
            if (r_state == S_S && r_dbusy && r_dcnt == 6'd63) begin
                r_k0 <= 32'sd0;
            end
            if (r_state == S_DIV0 && !r_dbusy) begin
                r_k0 <= (r_s[33] || r_s == 34'sd0) ? 32'sd0 : d_qsat[31:0];
            end
        end
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_filtered_angle = r_oa;
    assign o_unbiased_rate  = r_or;

`ifndef SYNTHESIS
    a_out_only_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_OUT))
        else $error("result valid outside output state");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state != S_IDLE))
        else $error("accepted word not started");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(r_oa)))
        else $error("stalled result changed");
`endif
endmodule
`default_nettype wire

// File: verif/abkf_checker.sv
// ----------------------------------------------------------------------------
// abkf_checker
// Watches the configuration port and both word channels of the angle /
// gyro-bias Kalman filter. It keeps its own copy of the filter state and
// noise registers, computes the expected result of every accepted input
// word, and compares each accepted result word with the oldest one.
// ----------------------------------------------------------------------------
`default_nettype none
module abkf_checker
    import abkf_pkg::*;
#(
    parameter int VALUE_WIDTH = ValueWidthDefault
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [1:0]                   i_cfg_idx,
    input  wire logic [NoiseWidth-1:0]        i_cfg_data,
    input  wire logic                         i_valid,
    input  wire logic                         i_stall_in,
    input  wire logic                         i_cmd,
    input  wire logic signed [FieldWidth-1:0] i_measured_angle,
    input  wire logic signed [FieldWidth-1:0] i_gyro_rate,
    input  wire logic [DtWidth-1:0]           i_time_step,
    input  wire logic                         i_out_valid,
    input  wire logic                         i_out_stall,
    input  wire logic signed [FieldWidth-1:0] i_filtered_angle,
    input  wire logic signed [FieldWidth-1:0] i_unbiased_rate,
    output int                                o_pending,
    output int                                o_errors
);
    localparam int WordBits = (VALUE_WIDTH > 32) ? 32 : (VALUE_WIDTH < 16) ? 16 : VALUE_WIDTH;

    typedef struct packed {
        logic signed [FieldWidth-1:0] angle;
        logic signed [FieldWidth-1:0] rate;
    } t_filter_out;

    t_filter_out expected_q[$];

    longint angle_noise, bias_noise, meas_noise;
    longint angle_est, bias_est, rate_est;
    longint p00, p01, p10, p11;

    function automatic longint clip(input longint x);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (WordBits - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) return hi;
        if (x < lo) return lo;
        return x;
    endfunction

    // round half up
    function automatic longint rnd_shift(input longint p, input int s);
        return (p + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint kalman_gain(input longint num, input longint s);
        if (s <= 0) return 0;
        return clip((num <<< FracQ28) / s);
    endfunction

    task automatic filter_step(input logic cmd, input longint meas, input longint gyro,
                               input longint dt);
        longint dtp11, t, s, k0, k1, y, c00, c01;
        if (cmd == CmdLoad) begin
            angle_est = clip(meas);
        end else begin
            rate_est  = clip(gyro - bias_est);
            angle_est = clip(angle_est + rnd_shift(dt * rate_est, FracDt));
            dtp11     = rnd_shift(dt * p11, FracDt);
            t         = clip(dtp11 - p01 - p10 + angle_noise);
            p00       = clip(p00 + rnd_shift(dt * t, FracDt));
            p01       = clip(p01 - dtp11);
            p10       = clip(p10 - dtp11);
            p11       = clip(p11 + rnd_shift(bias_noise * dt, FracDt));
            s         = p00 + meas_noise;
            k0        = kalman_gain(p00, s);
            k1        = kalman_gain(p10, s);
            y         = clip(meas - angle_est);
            angle_est = clip(angle_est + rnd_shift(k0 * y, FracQ28));
            bias_est  = clip(bias_est + rnd_shift(k1 * y, FracQ28));
            c00       = p00;
            c01       = p01;
            p00       = clip(p00 - rnd_shift(k0 * c00, FracQ28));
            p01       = clip(p01 - rnd_shift(k0 * c01, FracQ28));
            p10       = clip(p10 - rnd_shift(k1 * c00, FracQ28));
            p11       = clip(p11 - rnd_shift(k1 * c01, FracQ28));
        end
        expected_q.push_back('{angle: angle_est[31:0], rate: rate_est[31:0]});
    endtask

    always @(posedge i_clk) begin
        t_filter_out exp_w;
        if (!i_rst_n) begin
            angle_noise = longint'(AngleNoiseReset);
            bias_noise  = longint'(BiasNoiseReset);
            meas_noise  = longint'(MeasNoiseReset);
            angle_est = 0; bias_est = 0; rate_est = 0;
            p00 = 0; p01 = 0; p10 = 0; p11 = 0;
            expected_q.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    t_REG_ANGLE_NOISE: angle_noise = longint'(i_cfg_data);
                    t_REG_BIAS_NOISE:  bias_noise  = longint'(i_cfg_data);
                    t_REG_MEAS_NOISE:  meas_noise  = longint'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result word angle=%0d rate=%0d", $time,
                             i_filtered_angle, i_unbiased_rate);
                    o_errors++;
                end else begin
                    exp_w = expected_q.pop_front();
                    if (exp_w.angle !== i_filtered_angle) begin
                        $display("%0t: filtered_angle expected %0d actual %0d", $time,
                                 exp_w.angle, i_filtered_angle);
                        o_errors++;
                    end
                    if (exp_w.rate !== i_unbiased_rate) begin
                        $display("%0t: unbiased_rate expected %0d actual %0d", $time,
                                 exp_w.rate, i_unbiased_rate);
                        o_errors++;
                    end
                end
            end
            if (i_valid && !i_stall_in)
                filter_step(i_cmd, longint'(i_measured_angle), longint'(i_gyro_rate),
                            longint'(i_time_step));
        end
        o_pending = expected_q.size();
    end
endmodule
`default_nettype wire

// File: verif/tb_angle_bias_kalman_filter.sv
// ----------------------------------------------------------------------------
// tb_angle_bias_kalman_filter
// Stimulus and verdict for the angle / gyro-bias Kalman filter. Directed
// words hit field extremes, load words and a zero innovation variance;
// random phases under several noise settings mix realistic IMU streams with
// full-range noise, bursty input, a patterned output stall and one long
// output hold-off. Checking is done by abkf_checker.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_angle_bias_kalman_filter
    import abkf_pkg::*;
;
    localparam logic [1:0] RegUnused = 2'd3;
    localparam int         IdleLimit = 10000;
    localparam logic [30:0] NoiseMax = 31'h7FFF_FFFF;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [1:0]                   i_cfg_idx;
    logic [NoiseWidth-1:0]        i_cfg_data;
    logic                         i_valid;
    logic                         o_stall;
    logic                         i_cmd;
    logic signed [FieldWidth-1:0] i_measured_angle;
    logic signed [FieldWidth-1:0] i_gyro_rate;
    logic [DtWidth-1:0]           i_time_step;
    logic                         o_valid;
    logic                         i_stall;
    logic signed [FieldWidth-1:0] o_filtered_angle;
    logic signed [FieldWidth-1:0] o_unbiased_rate;
    int                           pending;
    int                           errors;
    logic                         hold_req;
    int                           burst_left;

    angle_bias_kalman_filter DUT (.*);

    abkf_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data, .i_valid,
        .i_stall_in(o_stall), .i_cmd, .i_measured_angle, .i_gyro_rate, .i_time_step,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_filtered_angle(o_filtered_angle), .i_unbiased_rate(o_unbiased_rate),
        .o_pending(pending), .o_errors(errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin
        int mode;
        logic hold_done;
        i_stall = 1'b0;
        hold_done = 1'b0;
        forever begin
            if (hold_req && !hold_done) begin
                i_stall = 1'b1;
                repeat (3000) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                mode = $urandom_range(0, 3);
                repeat ($urandom_range(16, 96)) begin
                    @(negedge i_clk);
                    case (mode)
                        0: i_stall = 1'b0;
                        1: i_stall = ($urandom_range(0, 1) == 0);
                        2: i_stall = ($urandom_range(0, 9) != 0);
                        default: i_stall = ($urandom_range(0, 9) == 0);
                    endcase
                end
            end
        end
    end

    // no acceptance on either channel for too long
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle = 0;
            else idle++;
            if (idle >= IdleLimit) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic send_word(input logic cmd, input logic [31:0] meas, input logic [31:0] gyro,
                             input logic [15:0] dt);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                i_valid = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        i_valid          = 1'b1;
        i_cmd            = cmd;
        i_measured_angle = meas;
        i_gyro_rate      = gyro;
        i_time_step      = dt;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_idle;
        i_valid = 1'b0;
        burst_left = 0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_noise(input logic [1:0] idx, input logic [30:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic random_word;
        if ($urandom_range(0, 99) < 85) begin
            send_word(($urandom_range(0, 19) == 0) ? CmdLoad : CmdUpdate,
                      32'($urandom_range(0, 180 << 16)) - 32'(90 << 16),
                      32'($urandom_range(0, 1000 << 16)) - 32'(500 << 16),
                      16'($urandom_range(1, 2000)));
        end else begin
            send_word(1'($urandom), $urandom, $urandom, 16'($urandom));
        end
    endtask

    initial begin
        logic [30:0] n0, n1, n2;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = t_REG_ANGLE_NOISE; i_cfg_data = '0;
        i_valid = 1'b0; i_cmd = CmdUpdate; i_measured_angle = '0; i_gyro_rate = '0;
        i_time_step = '0; hold_req = 1'b0; burst_left = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // zero angle and measurement noise and zero dt: innovation variance is zero, gains vanish
        write_noise(t_REG_ANGLE_NOISE, '0);
        write_noise(t_REG_MEAS_NOISE, '0);
        send_word(CmdUpdate, 32'sd65536, 32'sd1000, 16'd0);
        send_word(CmdUpdate, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0);
        wait_idle();
        write_noise(t_REG_ANGLE_NOISE, AngleNoiseReset);
        write_noise(t_REG_MEAS_NOISE, MeasNoiseReset);
        write_noise(RegUnused, NoiseMax);
        send_word(CmdLoad, 32'h7FFF_FFFF, 32'h0, 16'd0);
        send_word(CmdLoad, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
        send_word(CmdUpdate, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
        send_word(CmdUpdate, 32'h8000_0000, 32'h8000_0000, 16'hFFFF);
        send_word(CmdUpdate, 32'h8000_0000, 32'h7FFF_FFFF, 16'd1);
        send_word(CmdUpdate, 32'h0, 32'h0, 16'd0);
        send_word(CmdLoad, 32'h0, 32'h0, 16'd0);
        repeat (10) send_word(CmdUpdate, 32'sd655360, 32'sd6553, 16'd655);
        send_word(CmdUpdate, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        wait_idle();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin n0 = AngleNoiseReset; n1 = BiasNoiseReset; n2 = MeasNoiseReset; end
                1: begin n0 = '0; n1 = '0; n2 = '0; end
                2: begin n0 = NoiseMax; n1 = NoiseMax; n2 = NoiseMax; end
                3: begin n0 = NoiseMax; n1 = '0; n2 = 31'($urandom); end
                default: begin n0 = 31'($urandom); n1 = 31'($urandom); n2 = 31'($urandom); end
            endcase
            write_noise(t_REG_ANGLE_NOISE, n0);
            write_noise(t_REG_BIAS_NOISE, n1);
            write_noise(t_REG_MEAS_NOISE, n2);
            if (phase == 2) hold_req = 1'b1;
            repeat (200) random_word();
            wait_idle();
        end

        repeat (200) @(negedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire
